@@ rtl/core/rpdts_pkg.sv @@
package rpdts_pkg;

  // default geometry
  localparam int SCREEN_W_DEF = 120;
  localparam int SCREEN_H_DEF = 60;
  localparam int ORIGIN_X_DEF = 50;
  localparam int ORIGIN_Y_DEF = 45;

  // fixed field and datapath widths
  localparam int COORD_W   = 16;           // Q8.8 point coordinates
  localparam int COEF_W    = 16;           // Q1.14 sines and cosines
  localparam int PQR_W     = COORD_W + 1;  // remapped coordinate, holds -(-32768)
  localparam int DEPTH_W   = 20;           // Q0.20 reciprocal depth
  localparam int MA_W      = 29;           // shared multiplier, first operand
  localparam int MB_W      = 25;           // shared multiplier, second operand
  localparam int PROD_W    = MA_W + MB_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int FRAC_SH   = 14;           // Q1.14 product alignment
  localparam int PROJ_SH   = 28;           // reciprocal numerator and projection shift
  localparam int KO_W      = 28;           // proj_scale * depth
  localparam int ZD_W      = 22;           // positive z + eye distance
  localparam int CNT_W     = 5;
  localparam int SHADE_MAX = 11;
  localparam int ONE_Q14   = 16384;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  typedef enum logic [2:0] {
    REG_SIN_A    = 3'd0,
    REG_COS_A    = 3'd1,
    REG_SIN_B    = 3'd2,
    REG_COS_B    = 3'd3,
    REG_SIN_C    = 3'd4,
    REG_COS_C    = 3'd5,
    REG_SCALE    = 3'd6,
    REG_EYE_DIST = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    FACE_FRONT = 3'd0,
    FACE_BACK  = 3'd1,
    FACE_RIGHT = 3'd2,
    FACE_LEFT  = 3'd3,
    FACE_FLOOR = 3'd4,
    FACE_CEIL  = 3'd5
  } face_t;

  typedef enum logic {
    CMD_PLOT  = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_t;

  typedef enum logic [12:0] {
    ST_CLEAR = 13'b0000000000001,
    ST_IDLE  = 13'b0000000000010,
    ST_LIGHT = 13'b0000000000100,
    ST_SHADE = 13'b0000000001000,
    ST_ROT   = 13'b0000000010000,
    ST_ZD    = 13'b0000000100000,
    ST_DIV   = 13'b0000001000000,
    ST_KO    = 13'b0000010000000,
    ST_COL   = 13'b0000100000000,
    ST_ROW   = 13'b0001000000000,
    ST_IDX   = 13'b0010000000000,
    ST_RD    = 13'b0100000000000,
    ST_CMP   = 13'b1000000000000
  } state_t;

endpackage

@@ rtl/core/rotate_project_depth_test_splat.sv @@
// Channel  | Direction | Handshake              | Payload
// s_axis   | in        | s_axis_tvalid/tready   | tuser {face, cmd}, tdata {color, w, v, u}
// m_axis   | out       | m_axis_tvalid/tready   | tdata {pix_color, shade, pix_row, pix_col}
// cfg      | in        | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// A plot beat holds the sequencer from acceptance until it returns to idle, in order:
// lighting and shade, 12 rotation multiply-accumulates, eye offset, bit-serial reciprocal,
// projection and depth read-compare-write; a saturated reciprocal skips the divide.
// Reset and each clear beat sweep all SCREEN_W*SCREEN_H depth entries (7200 by default),
// one entry a cycle, with no beat accepted. Config is taken in any cycle.
// A pixel waits in the output register; a following pixel stalls at its depth write.
module rotate_project_depth_test_splat #(
  parameter int SCREEN_W = rpdts_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H = rpdts_pkg::SCREEN_H_DEF,
  parameter int ORIGIN_X = rpdts_pkg::ORIGIN_X_DEF,
  parameter int ORIGIN_Y = rpdts_pkg::ORIGIN_Y_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // coord_u[15:0], coord_v[31:16], coord_w[47:32],
                                      // color[51:48], zero fill
  input  logic [3:0]  s_axis_tuser,   // cmd[0], face[3:1]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // pix_col[6:0], pix_row[12:7], shade[16:13],
                                      // pix_color[20:17], zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int DEPTH = SCREEN_W * SCREEN_H;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(SCREEN_W);
  localparam int YW    = $clog2(SCREEN_H);
  localparam int PT_W  = rpdts_pkg::ACC_W - rpdts_pkg::PROJ_SH;

  // configuration registers
  logic signed [rpdts_pkg::COEF_W-1:0] sin_a, cos_a, sin_b, cos_b, sin_c, cos_c;
  logic [7:0] proj_scale, eye_distance;

  // sequencer and datapath registers
  rpdts_pkg::state_t state;
  logic [3:0] k;
  logic [rpdts_pkg::CNT_W-1:0] dcnt;
  logic [AW-1:0] clr_idx;
  logic [2:0] face_r;
  logic [3:0] color_r;
  logic signed [rpdts_pkg::PQR_W-1:0] p, q, r;
  logic signed [31:0] light;
  logic [3:0] shade;
  logic signed [rpdts_pkg::ACC_W-1:0] acc;
  logic signed [18:0] a, b;
  logic signed [21:0] m, z;
  logic signed [24:0] x, y;
  logic [rpdts_pkg::ZD_W-1:0] zd_r, rem;
  logic [rpdts_pkg::DEPTH_W-1:0] quo, o;
  logic [rpdts_pkg::KO_W-1:0] ko;
  logic [XW-1:0] col_r;
  logic [YW-1:0] row_r;
  logic [AW-1:0] idx;

  // depth memory
  logic [rpdts_pkg::DEPTH_W-1:0] depth_mem [DEPTH];
  logic [rpdts_pkg::DEPTH_W-1:0] rdata;
  logic mem_we;
  logic [AW-1:0] mem_waddr;
  logic [rpdts_pkg::DEPTH_W-1:0] mem_wdata;

  // output register
  logic out_valid;
  logic [23:0] out_data;
  logic out_load;

  // input fields
  logic in_fire;
  logic signed [rpdts_pkg::COORD_W-1:0] in_u, in_v, in_w;
  logic [2:0] in_face;
  logic signed [rpdts_pkg::PQR_W-1:0] p_in, q_in, r_in;

  // shared unit
  logic signed [rpdts_pkg::MA_W-1:0] ma;
  logic signed [rpdts_pkg::MB_W-1:0] mb;
  logic signed [rpdts_pkg::PROD_W-1:0] prod;
  logic mac_sub;
  logic signed [rpdts_pkg::ACC_W-1:0] mac_sum, mac_sh;

  logic signed [22:0] zd_c;
  logic [rpdts_pkg::ZD_W:0] trial;
  logic [rpdts_pkg::DEPTH_W-1:0] quo_next;
  logic [35:0] light11;
  logic [7:0] shade_raw;
  logic signed [rpdts_pkg::ACC_W-1:0] org_term, proj_sum;
  logic signed [PT_W-1:0] pt, pt_adj;
  logic on_grid;
  logic win;

  function automatic logic signed [rpdts_pkg::PQR_W-1:0] PQR_EXT(
    input logic signed [rpdts_pkg::COORD_W-1:0] val
  );
    return rpdts_pkg::PQR_W'(val);
  endfunction

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == rpdts_pkg::ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  assign in_u    = s_axis_tdata[15:0];
  assign in_v    = s_axis_tdata[31:16];
  assign in_w    = s_axis_tdata[47:32];
  assign in_face = s_axis_tuser[3:1];

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sin_a        <= '0;
      cos_a        <= 16'(rpdts_pkg::ONE_Q14);
      sin_b        <= '0;
      cos_b        <= 16'(rpdts_pkg::ONE_Q14);
      sin_c        <= '0;
      cos_c        <= 16'(rpdts_pkg::ONE_Q14);
      proj_scale   <= 8'd40;
      eye_distance <= 8'd40;
    end else if (cfg_valid && cfg_ready) begin
      unique case (rpdts_pkg::cfg_reg_t'(cfg_index))
        rpdts_pkg::REG_SIN_A:    sin_a        <= cfg_data;
        rpdts_pkg::REG_COS_A:    cos_a        <= cfg_data;
        rpdts_pkg::REG_SIN_B:    sin_b        <= cfg_data;
        rpdts_pkg::REG_COS_B:    cos_b        <= cfg_data;
        rpdts_pkg::REG_SIN_C:    sin_c        <= cfg_data;
        rpdts_pkg::REG_COS_C:    cos_c        <= cfg_data;
        rpdts_pkg::REG_SCALE:    proj_scale   <= cfg_data[7:0];
        rpdts_pkg::REG_EYE_DIST: eye_distance <= cfg_data[7:0];
      endcase
    end
  end

  // per-face remap of the incoming point
  always_comb begin
    if (in_face <= rpdts_pkg::FACE_BACK) begin
      p_in = PQR_EXT(in_u);
      q_in = PQR_EXT(in_v);
      r_in = PQR_EXT(in_w);
    end else if (in_face <= rpdts_pkg::FACE_LEFT) begin
      p_in = PQR_EXT(in_w);
      q_in = PQR_EXT(in_u);
      r_in = -PQR_EXT(in_v);
    end else begin
      p_in = PQR_EXT(in_u);
      q_in = PQR_EXT(in_w);
      r_in = -PQR_EXT(in_v);
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    ma      = '0;
    mb      = '0;
    mac_sub = 1'b0;
    unique case (state)
      rpdts_pkg::ST_LIGHT: begin
        if (face_r <= rpdts_pkg::FACE_BACK) begin
          ma = rpdts_pkg::MA_W'(cos_a);
          mb = rpdts_pkg::MB_W'(cos_b);
        end else if (face_r <= rpdts_pkg::FACE_LEFT) begin
          ma = rpdts_pkg::MA_W'(sin_a);
          mb = rpdts_pkg::MB_W'(cos_b);
        end else begin
          ma = rpdts_pkg::MA_W'(sin_b);
          mb = rpdts_pkg::MB_W'(rpdts_pkg::ONE_Q14);
        end
      end
      rpdts_pkg::ST_ROT: begin
        unique case (k)
          4'd0:  begin ma = rpdts_pkg::MA_W'(cos_a); mb = rpdts_pkg::MB_W'(p); end
          4'd1:  begin ma = rpdts_pkg::MA_W'(sin_a); mb = rpdts_pkg::MB_W'(r); end
          4'd2:  begin ma = rpdts_pkg::MA_W'(sin_a); mb = rpdts_pkg::MB_W'(p); end
          4'd3:  begin ma = rpdts_pkg::MA_W'(cos_a); mb = rpdts_pkg::MB_W'(r); mac_sub = 1'b1; end
          4'd4:  begin ma = rpdts_pkg::MA_W'(cos_b); mb = rpdts_pkg::MB_W'(q); end
          4'd5:  begin ma = rpdts_pkg::MA_W'(sin_b); mb = rpdts_pkg::MB_W'(b); end
          4'd6:  begin ma = rpdts_pkg::MA_W'(cos_c); mb = rpdts_pkg::MB_W'(a); end
          4'd7:  begin ma = rpdts_pkg::MA_W'(sin_c); mb = rpdts_pkg::MB_W'(m); end
          4'd8:  begin ma = rpdts_pkg::MA_W'(cos_c); mb = rpdts_pkg::MB_W'(m); end
          4'd9:  begin ma = rpdts_pkg::MA_W'(sin_c); mb = rpdts_pkg::MB_W'(a); mac_sub = 1'b1; end
          4'd10: begin ma = rpdts_pkg::MA_W'(cos_b); mb = rpdts_pkg::MB_W'(b); end
          4'd11: begin ma = rpdts_pkg::MA_W'(sin_b); mb = rpdts_pkg::MB_W'(q); mac_sub = 1'b1; end
          default: begin ma = '0; mb = '0; end
        endcase
      end
      rpdts_pkg::ST_KO: begin
        ma = $signed(rpdts_pkg::MA_W'(proj_scale));
        mb = $signed(rpdts_pkg::MB_W'(o));
      end
      rpdts_pkg::ST_COL: begin
        ma = $signed(rpdts_pkg::MA_W'(ko));
        mb = x;
      end
      rpdts_pkg::ST_ROW: begin
        ma = $signed(rpdts_pkg::MA_W'(ko));
        mb = y;
      end
      rpdts_pkg::ST_IDX: begin
        ma = $signed(rpdts_pkg::MA_W'(row_r));
        mb = $signed(rpdts_pkg::MB_W'(SCREEN_W));
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod    = ma * mb;
  assign mac_sum = mac_sub ? acc - rpdts_pkg::ACC_W'(prod) : acc + rpdts_pkg::ACC_W'(prod);
  assign mac_sh  = mac_sum >>> rpdts_pkg::FRAC_SH;

  // shade from the lighting term, light known non-negative here
  assign light11   = (36'(light) << 3) + (36'(light) << 1) + 36'(light);
  assign shade_raw = light11[35:28];

  // eye distance offset
  assign zd_c = 23'(z) + $signed({7'b0, eye_distance, 8'b0});

  // restoring divide step, numerator is a single one at bit 28
  assign trial    = {rem, dcnt == rpdts_pkg::CNT_W'(rpdts_pkg::PROJ_SH)};
  assign quo_next = {quo[rpdts_pkg::DEPTH_W-2:0], trial >= {1'b0, zd_r}};

  // projection with truncation toward zero
  assign org_term = rpdts_pkg::ACC_W'(state == rpdts_pkg::ST_ROW ? ORIGIN_Y : ORIGIN_X)
                    <<< rpdts_pkg::PROJ_SH;
  assign proj_sum = rpdts_pkg::ACC_W'(prod) + org_term;
  assign pt       = proj_sum[rpdts_pkg::ACC_W-1:rpdts_pkg::PROJ_SH];
  assign pt_adj   = pt + PT_W'(proj_sum[rpdts_pkg::ACC_W-1] &&
                               (proj_sum[rpdts_pkg::PROJ_SH-1:0] != '0));
  assign on_grid  = !pt_adj[PT_W-1] &&
                    (pt_adj < $signed(PT_W'(state == rpdts_pkg::ST_ROW ? SCREEN_H : SCREEN_W)));

  assign win      = o > rdata;
  assign out_load = (state == rpdts_pkg::ST_CMP) && win && (!out_valid || m_axis_tready);

  // depth memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = o;
    if (state == rpdts_pkg::ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx;
      mem_wdata = '0;
    end else if (out_load) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) depth_mem[mem_waddr] <= mem_wdata;
    if (state == rpdts_pkg::ST_RD) rdata <= depth_mem[idx];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= rpdts_pkg::ST_CLEAR;
      clr_idx <= '0;
      k       <= '0;
      dcnt    <= '0;
    end else begin
      unique case (state)
        rpdts_pkg::ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == AW'(DEPTH - 1)) state <= rpdts_pkg::ST_IDLE;
        end
        rpdts_pkg::ST_IDLE: begin
          if (in_fire) begin
            if (s_axis_tuser[0] == rpdts_pkg::CMD_CLEAR) begin
              clr_idx <= '0;
              state   <= rpdts_pkg::ST_CLEAR;
            end else if (in_face <= rpdts_pkg::FACE_CEIL) begin
              state <= rpdts_pkg::ST_LIGHT;
            end
          end
        end
        rpdts_pkg::ST_LIGHT: state <= rpdts_pkg::ST_SHADE;
        rpdts_pkg::ST_SHADE: begin
          k     <= '0;
          state <= light[31] ? rpdts_pkg::ST_IDLE : rpdts_pkg::ST_ROT;
        end
        rpdts_pkg::ST_ROT: begin
          k <= k + 1'b1;
          if (k == 4'd11) state <= rpdts_pkg::ST_ZD;
        end
        rpdts_pkg::ST_ZD: begin
          dcnt <= rpdts_pkg::CNT_W'(rpdts_pkg::PROJ_SH);
          if (zd_c <= 0) state <= rpdts_pkg::ST_IDLE;
          else if (zd_c <= 23'sd256) state <= rpdts_pkg::ST_KO;
          else state <= rpdts_pkg::ST_DIV;
        end
        rpdts_pkg::ST_DIV: begin
          dcnt <= dcnt - 1'b1;
          if (dcnt == '0) state <= rpdts_pkg::ST_KO;
        end
        rpdts_pkg::ST_KO:  state <= rpdts_pkg::ST_COL;
        rpdts_pkg::ST_COL: state <= on_grid ? rpdts_pkg::ST_ROW : rpdts_pkg::ST_IDLE;
        rpdts_pkg::ST_ROW: state <= on_grid ? rpdts_pkg::ST_IDX : rpdts_pkg::ST_IDLE;
        rpdts_pkg::ST_IDX: state <= rpdts_pkg::ST_RD;
        rpdts_pkg::ST_RD:  state <= rpdts_pkg::ST_CMP;
        rpdts_pkg::ST_CMP: begin
          if (!win || out_load) state <= rpdts_pkg::ST_IDLE;
        end
        default: state <= rpdts_pkg::ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      rpdts_pkg::ST_IDLE: begin
        face_r  <= in_face;
        color_r <= s_axis_tdata[51:48];
        p       <= p_in;
        q       <= q_in;
        r       <= r_in;
      end
      rpdts_pkg::ST_LIGHT: begin
        if (face_r == rpdts_pkg::FACE_BACK || face_r == rpdts_pkg::FACE_RIGHT ||
            face_r == rpdts_pkg::FACE_CEIL)
          light <= -32'(prod);
        else
          light <= 32'(prod);
      end
      rpdts_pkg::ST_SHADE: begin
        shade <= (shade_raw > 8'(rpdts_pkg::SHADE_MAX)) ? 4'(rpdts_pkg::SHADE_MAX)
                                                          : shade_raw[3:0];
      end
      rpdts_pkg::ST_ROT: begin
        if (!k[0]) begin
          acc <= rpdts_pkg::ACC_W'(prod);
        end else begin
          unique case (k)
            4'd1:    a <= 19'(mac_sh);
            4'd3:    b <= 19'(mac_sh);
            4'd5:    m <= 22'(mac_sh);
            4'd7:    x <= 25'(mac_sh);
            4'd9:    y <= 25'(mac_sh);
            default: z <= 22'(mac_sh);
          endcase
        end
      end
      rpdts_pkg::ST_ZD: begin
        zd_r <= zd_c[rpdts_pkg::ZD_W-1:0];
        rem  <= '0;
        quo  <= '0;
        o    <= rpdts_pkg::DEPTH_MAX;
      end
      rpdts_pkg::ST_DIV: begin
        quo <= quo_next;
        if (trial >= {1'b0, zd_r}) rem <= rpdts_pkg::ZD_W'(trial - {1'b0, zd_r});
        else rem <= trial[rpdts_pkg::ZD_W-1:0];
        if (dcnt == '0) o <= quo_next;
      end
      rpdts_pkg::ST_KO:  ko    <= rpdts_pkg::KO_W'(prod);
      rpdts_pkg::ST_COL: col_r <= XW'(pt_adj);
      rpdts_pkg::ST_ROW: row_r <= YW'(pt_adj);
      rpdts_pkg::ST_IDX: idx   <= AW'(prod) + AW'(col_r);
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data <= {3'b0, color_r, shade, 6'(row_r), 7'(col_r)};
  end

  // checks
  a_pix_from_cmp: assert property (@(posedge clk) disable iff (rst)
    out_load |-> $past(state == rpdts_pkg::ST_RD) || $past(state == rpdts_pkg::ST_CMP))
    else $error("pixel loaded without a fresh depth read");

  a_recip_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == rpdts_pkg::ST_KO) |-> (o != '0))
    else $error("reciprocal depth is zero");

  a_pix_on_grid: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (32'(col_r) < SCREEN_W) && (32'(row_r) < SCREEN_H))
    else $error("pixel off the grid");

  a_no_pix_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == rpdts_pkg::ST_CLEAR) |=> !$rose(out_valid))
    else $error("pixel produced during depth clear");

endmodule
